>>> hw/rtl/round_robin_free_list_allocator_defines.svh
// Assertion macros for the round-robin free-list allocator.
// Included by the top level; expects clk and rst_n in scope.
`ifndef ROUND_ROBIN_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define ROUND_ROBIN_FREE_LIST_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRFL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RRFL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rrfl_pkg.sv
// Shared types and constants for the round-robin free-list allocator.
// No dependencies; the front, back and top-level RTL files use this package.
`timescale 1ns / 1ps
`default_nettype none

package rrfl_pkg;

    localparam int IDX_W  = 10;
    localparam int SUB_W  = 6;
    localparam int WIDE_W = 18;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] free_index;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0] alloc_index;
        logic [1:0]       status;
    } result_t;

    typedef struct packed {
        logic             op;
        logic [SUB_W-1:0] sub;
        logic [IDX_W-1:0] index;
        logic             in_range;
    } cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/rrfl_fifo.sv
// Small register-based word queue used between the allocator stages.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module rrfl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = data_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rrfl_front.sv
// Front end of the allocator: accepts words, keeps the round-robin pointer and
// maps a freed index to its submanager. Depends on rrfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrfl_front #(
    parameter int POOL_SIZE = 1024,
    parameter int SUB_COUNT = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  rrfl_pkg::item_t item,
    input  logic           push,
    output logic           full,
    output rrfl_pkg::cmd_t cmd,
    output logic           cmd_push,
    input  logic           cmd_full
);

    localparam int PER_SUB   = POOL_SIZE / SUB_COUNT;
    localparam int USED_SIZE = PER_SUB * SUB_COUNT;
    localparam int SW        = (SUB_COUNT > 1) ? $clog2(SUB_COUNT) : 1;
    localparam int SUB_W     = rrfl_pkg::SUB_W;
    localparam int WIDE_W    = rrfl_pkg::WIDE_W;

    logic [SW-1:0]        rr_reg, rr_next;
    logic [SUB_COUNT-1:0] above_bound;
    logic [SUB_W-1:0]     free_sub;
    logic                 in_range;

    always_comb
    begin
        above_bound = '0;
        for (int k = 1; k < SUB_COUNT; k++)
        begin
            above_bound[k] = WIDE_W'(item.free_index) >= WIDE_W'(k * PER_SUB);
        end
    end

    assign free_sub = SUB_W'($countones(above_bound));
    assign in_range = WIDE_W'(item.free_index) < WIDE_W'(USED_SIZE);

    always_comb
    begin
        cmd.op       = item.op;
        cmd.index    = item.free_index;
        cmd.in_range = in_range;
        cmd.sub      = (item.op == rrfl_pkg::OP_ALLOC) ? SUB_W'(rr_reg) : free_sub;
    end

    assign full     = cmd_full;
    assign cmd_push = push && !cmd_full;

    always_comb
    begin
        rr_next = rr_reg;
        if (cmd_push && (item.op == rrfl_pkg::OP_ALLOC))
        begin
            rr_next = (rr_reg == SW'(SUB_COUNT - 1)) ? '0 : rr_reg + SW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rr_reg <= '0;
        end
        else
        begin
            rr_reg <= rr_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rrfl_back.sv
// Back end of the allocator: free stacks, allocated map and per-submanager
// counts, updated by a memory read and then a memory write. Depends on rrfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrfl_back #(
    parameter int POOL_SIZE = 1024,
    parameter int SUB_COUNT = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rrfl_pkg::cmd_t    cmd,
    input  logic              cmd_empty,
    output logic              cmd_pop,
    output rrfl_pkg::result_t res,
    output logic              res_push,
    input  logic              res_full
);

    localparam int PER_SUB   = POOL_SIZE / SUB_COUNT;
    localparam int USED_SIZE = PER_SUB * SUB_COUNT;
    localparam int DEPTH     = (USED_SIZE > 0) ? USED_SIZE : 1;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW        = $clog2(POOL_SIZE);
    localparam int SW        = (SUB_COUNT > 1) ? $clog2(SUB_COUNT) : 1;
    localparam int CNT_W     = (PER_SUB > 0) ? $clog2(PER_SUB + 1) : 1;
    localparam int IDX_W     = rrfl_pkg::IDX_W;
    localparam int WIDE_W    = rrfl_pkg::WIDE_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t         state_reg, state_next;
    rrfl_pkg::cmd_t cmd_reg, cmd_next;

    logic [CNT_W-1:0] cnt_reg [SUB_COUNT];
    logic [CNT_W-1:0] min_reg [SUB_COUNT];

    logic [IW-1:0] stack_mem [DEPTH];
    logic          map_mem [DEPTH];
    logic [IW-1:0] stack_q_reg;
    logic          map_q_reg;

    logic              take;
    logic [SW-1:0]     s_in;
    logic [WIDE_W-1:0] base_in;
    logic [AW-1:0]     stack_rd_addr;
    logic [AW-1:0]     map_rd_addr;

    logic [SW-1:0]     s;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  mn;
    logic [WIDE_W-1:0] base;
    logic [WIDE_W-1:0] alloc_val;
    logic [WIDE_W-1:0] offset;
    logic              touched;

    logic             cnt_we;
    logic [CNT_W-1:0] cnt_wr_val;
    logic             min_we;
    logic [CNT_W-1:0] min_wr_val;
    logic             stack_we;
    logic [AW-1:0]    stack_wr_addr;
    logic [IW-1:0]    stack_wr_data;
    logic             map_we;
    logic [AW-1:0]    map_wr_addr;
    logic             map_wr_data;

    assign take          = (state_reg == ST_IDLE) && !cmd_empty && !res_full;
    assign s_in          = cmd.sub[SW-1:0];
    assign base_in       = WIDE_W'(WIDE_W'(s_in) * WIDE_W'(PER_SUB));
    assign stack_rd_addr = AW'(base_in + WIDE_W'(cnt_reg[s_in]) - WIDE_W'(1));
    assign map_rd_addr   = AW'(cmd.index);

    assign s         = cmd_reg.sub[SW-1:0];
    assign cnt       = cnt_reg[s];
    assign mn        = min_reg[s];
    assign base      = WIDE_W'(WIDE_W'(s) * WIDE_W'(PER_SUB));
    assign alloc_val = (mn == cnt) ? base + WIDE_W'(PER_SUB) - WIDE_W'(cnt)
                                   : WIDE_W'(stack_q_reg);
    assign offset    = WIDE_W'(cmd_reg.index) - base;
    assign touched   = offset < (WIDE_W'(PER_SUB) - WIDE_W'(mn));

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        res.alloc_index = '0;
        res.status      = rrfl_pkg::STATUS_OK;
        cnt_we          = 1'b0;
        cnt_wr_val      = cnt;
        min_we          = 1'b0;
        min_wr_val      = mn;
        stack_we        = 1'b0;
        stack_wr_addr   = AW'(base + WIDE_W'(cnt));
        stack_wr_data   = IW'(cmd_reg.index);
        map_we          = 1'b0;
        map_wr_addr     = AW'(cmd_reg.index);
        map_wr_data     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_push   = 1'b1;
                state_next = ST_IDLE;
                if (cmd_reg.op == rrfl_pkg::OP_ALLOC)
                begin
                    if (cnt == '0)
                    begin
                        res.status = rrfl_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        cnt_we          = 1'b1;
                        cnt_wr_val      = cnt - CNT_W'(1);
                        min_we          = (mn == cnt);
                        min_wr_val      = cnt - CNT_W'(1);
                        map_we          = 1'b1;
                        map_wr_addr     = AW'(alloc_val);
                        map_wr_data     = 1'b1;
                        res.alloc_index = IDX_W'(alloc_val);
                    end
                end
                else
                begin
                    if (cmd_reg.in_range && touched && map_q_reg
                        && (WIDE_W'(cnt) < WIDE_W'(PER_SUB)))
                    begin
                        cnt_we     = 1'b1;
                        cnt_wr_val = cnt + CNT_W'(1);
                        map_we     = 1'b1;
                        stack_we   = 1'b1;
                    end
                    else
                    begin
                        res.status = rrfl_pkg::STATUS_BAD_FREE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < SUB_COUNT; i++)
            begin
                cnt_reg[i] <= CNT_W'(PER_SUB);
                min_reg[i] <= CNT_W'(PER_SUB);
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cnt_we)
            begin
                cnt_reg[s] <= cnt_wr_val;
            end
            if (min_we)
            begin
                min_reg[s] <= min_wr_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stack_q_reg <= stack_mem[stack_rd_addr];
        end
        if (stack_we)
        begin
            stack_mem[stack_wr_addr] <= stack_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            map_q_reg <= map_mem[map_rd_addr];
        end
        if (map_we)
        begin
            map_mem[map_wr_addr] <= map_wr_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/round_robin_free_list_allocator.sv
// A word passes the command queue, the back's read state and write state, then the
// result queue. The back takes no new word until it has written the last result.
// The front takes words while the command queue has room, while the back works or waits.
// Reset empties the queues, zeroes the round-robin pointer and fills every stack count.
// No clearing pass: the block takes words in the first cycle after reset.
// Top level of the round-robin free-list allocator; uses rrfl_pkg and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "round_robin_free_list_allocator_defines.svh"

module round_robin_free_list_allocator #(
    parameter int POOL_SIZE = 1024,
    parameter int SUB_COUNT = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rrfl_pkg::item_t   item,
    input  logic              push,
    output logic              full,
    output rrfl_pkg::result_t result,
    output logic              empty,
    input  logic              pop
);

    rrfl_pkg::cmd_t    cmd_in;
    rrfl_pkg::cmd_t    cmd_out;
    rrfl_pkg::result_t res_word;
    logic              cmd_push;
    logic              cmd_full;
    logic              cmd_pop;
    logic              cmd_empty;
    logic              res_push;
    logic              res_full;
    logic              res_failed;
    logic              res_index_zero;

    rrfl_front #(
        .POOL_SIZE(POOL_SIZE),
        .SUB_COUNT(SUB_COUNT)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .push    (push),
        .full    (full),
        .cmd     (cmd_in),
        .cmd_push(cmd_push),
        .cmd_full(cmd_full)
    );

    rrfl_fifo #(
        .WIDTH($bits(rrfl_pkg::cmd_t)),
        .DEPTH(2)
    ) u_cmd_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_data(cmd_in),
        .full   (cmd_full),
        .rd_en  (cmd_pop),
        .rd_data(cmd_out),
        .empty  (cmd_empty)
    );

    rrfl_back #(
        .POOL_SIZE(POOL_SIZE),
        .SUB_COUNT(SUB_COUNT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_out),
        .cmd_empty(cmd_empty),
        .cmd_pop  (cmd_pop),
        .res      (res_word),
        .res_push (res_push),
        .res_full (res_full)
    );

    rrfl_fifo #(
        .WIDTH($bits(rrfl_pkg::result_t)),
        .DEPTH(2)
    ) u_res_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (res_push),
        .wr_data(res_word),
        .full   (res_full),
        .rd_en  (pop),
        .rd_data(result),
        .empty  (empty)
    );

    assign res_failed     = !empty && (result.status != rrfl_pkg::STATUS_OK);
    assign res_index_zero = (result.alloc_index == '0);

    `RRFL_ASSERT_SAME(a_cmd_pop_nonempty, cmd_pop, !cmd_empty, "command taken from empty queue")
    `RRFL_ASSERT_SAME(a_res_push_room, res_push, !res_full, "result written to full queue")
    `RRFL_ASSERT_NEXT(a_pop_then_result, cmd_pop, res_push && !cmd_pop, "result not written")
    `RRFL_ASSERT_SAME(a_fail_zero_index, res_failed, res_index_zero, "index on failed word")

endmodule

`default_nettype wire
